>>> src/sbt_pkg.sv
// ---------------------------------------------------------------------------
// sbt_pkg: shared types and helpers of the source byte tokenizer
// Token record, scanner modes, token kinds and byte classification.
// ---------------------------------------------------------------------------
`default_nettype none

package sbt_pkg;

  localparam int unsigned POSITION_BITS_DEF     = 20;
  localparam int unsigned MAX_COMMENT_DEPTH_DEF = 255;
  localparam int unsigned TOK_POS_W             = 20;
  localparam int unsigned PREFIX_LEN            = 6;

  localparam logic [5:0] K_END   = 6'd0;
  localparam logic [5:0] K_IDENT = 6'd1;
  localparam logic [5:0] K_INT   = 6'd2;
  localparam logic [5:0] K_STR   = 6'd3;
  localparam logic [5:0] K_FN    = 6'd10;
  localparam logic [5:0] K_LET   = 6'd11;
  localparam logic [5:0] K_MUT   = 6'd12;
  localparam logic [5:0] K_IF    = 6'd13;
  localparam logic [5:0] K_ELSE  = 6'd14;
  localparam logic [5:0] K_WHILE = 6'd15;
  localparam logic [5:0] K_RET   = 6'd16;
  localparam logic [5:0] K_SLASH = 6'd32;
  localparam logic [5:0] K_NONE  = 6'd0;

  typedef enum logic [3:0] {
    M_NORMAL, M_SLASH, M_LINE, M_BLOCK, M_BLOCK_SLASH, M_BLOCK_STAR,
    M_ATTR, M_ZERO, M_DEC, M_HEX, M_WORD, M_STRING, M_OP
  } mode_t;

  typedef struct packed {
    logic [5:0]           kind;
    logic [31:0]          value;
    logic [TOK_POS_W-1:0] start;
    logic [TOK_POS_W-1:0] length;
    logic                 last;
  } token_t;

  function automatic logic dec_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic word_lead(input logic [7:0] c);
    return (c == "_") || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic word_char(input logic [7:0] c);
    return word_lead(c) || dec_char(c);
  endfunction

  function automatic logic hex_char(input logic [7:0] c);
    return dec_char(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return (c == " ") || (c == 8'd9) || (c == 8'd10) || (c == 8'd13);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c <= "9") t = c - "0";
    else if (c <= "F") t = c - "A" + 8'd10;
    else t = c - "a" + 8'd10;
    return t[3:0];
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "(": k = 6'd20;
      ")": k = 6'd21;
      "{": k = 6'd22;
      "}": k = 6'd23;
      ",": k = 6'd24;
      ";": k = 6'd25;
      ":": k = 6'd26;
      "+": k = 6'd29;
      "*": k = 6'd31;
      "%": k = 6'd33;
      "^": k = 6'd42;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // Expected second character of a two-character operator; zero when the
  // byte cannot lead one.
  function automatic logic [7:0] op_second(input logic [7:0] c);
    logic [7:0] s;
    case (c)
      "=", "!", "<", ">": s = "=";
      "-": s = ">";
      "&": s = "&";
      "|": s = "|";
      default: s = 8'd0;
    endcase
    return s;
  endfunction

  function automatic logic [5:0] op_one(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "=": k = 6'd28;
      "!": k = 6'd45;
      "<": k = 6'd36;
      ">": k = 6'd38;
      "-": k = 6'd30;
      "&": k = 6'd40;
      default: k = 6'd41;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] op_two(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "=": k = 6'd34;
      "!": k = 6'd35;
      "<": k = 6'd37;
      ">": k = 6'd39;
      "-": k = 6'd27;
      "&": k = 6'd43;
      default: k = 6'd44;
    endcase
    return k;
  endfunction

  // Keyword lookup; byte 0 of the word sits in pre[7:0]. A length code of
  // seven stands for any word longer than six bytes.
  function automatic logic [5:0] kw_kind(input logic [47:0] pre, input logic [2:0] len);
    logic [5:0] k;
    k = K_IDENT;
    if (len == 3'd2 && pre[15:0] == {"n", "f"}) k = K_FN;
    if (len == 3'd3 && pre[23:0] == {"t", "e", "l"}) k = K_LET;
    if (len == 3'd3 && pre[23:0] == {"t", "u", "m"}) k = K_MUT;
    if (len == 3'd2 && pre[15:0] == {"f", "i"}) k = K_IF;
    if (len == 3'd4 && pre[31:0] == {"e", "s", "l", "e"}) k = K_ELSE;
    if (len == 3'd5 && pre[39:0] == {"e", "l", "i", "h", "w"}) k = K_WHILE;
    if (len == 3'd6 && pre[47:0] == {"n", "r", "u", "t", "e", "r"}) k = K_RET;
    return k;
  endfunction

endpackage

`default_nettype wire

>>> src/sbt_scan.sv
// ---------------------------------------------------------------------------
// sbt_scan: scanner state and per-byte token logic
// Holds the scan state and forms up to two tokens for each accepted request.
// ---------------------------------------------------------------------------
`default_nettype none

module sbt_scan import sbt_pkg::*; #(
  parameter int unsigned POSITION_BITS     = POSITION_BITS_DEF,
  parameter int unsigned MAX_COMMENT_DEPTH = MAX_COMMENT_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] c,
  input  wire logic       eos,
  output token_t          tok0,
  output token_t          tok1,
  output logic [1:0]      tok_n
);

  localparam int unsigned PW = POSITION_BITS;
  localparam int unsigned DW = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  mode_t          mode_r, mode_nxt;
  logic [DW-1:0]  depth_r, depth_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [PW-1:0]  pstart_r, pstart_nxt;
  logic [PW-1:0]  plen_r, plen_nxt;
  logic [31:0]    acc_r, acc_nxt;
  logic [7:0]     pop_r, pop_nxt;
  logic [7:0]     pre_r [PREFIX_LEN];
  logic           pre_we;
  logic [2:0]     pre_idx;
  logic [47:0]    pre_flat;
  logic [2:0]     len_code;
  logic [5:0]     word_k;
  logic           do_norm, flush_v, norm_v;
  token_t         flush_tok, norm_tok;
  logic [PW-1:0]  endpos;

  always_comb begin
    for (int i = 0; i < PREFIX_LEN; i++) pre_flat[i*8 +: 8] = pre_r[i];
    len_code = (plen_r <= PW'(PREFIX_LEN)) ? plen_r[2:0] : 3'd7;
    word_k   = kw_kind(pre_flat, len_code);
  end

  always_comb begin
    mode_nxt   = mode_r;
    depth_nxt  = depth_r;
    pos_nxt    = pos_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    acc_nxt    = acc_r;
    pop_nxt    = pop_r;
    pre_we     = 1'b0;
    pre_idx    = plen_r[2:0];
    do_norm    = 1'b0;
    flush_v    = 1'b0;
    norm_v     = 1'b0;
    flush_tok  = '0;
    norm_tok   = '0;
    endpos     = pos_r;
    if (take && eos) begin
      case (mode_r)
        M_SLASH: begin
          flush_v = 1'b1;
          flush_tok.kind = K_SLASH;
          flush_tok.start = TOK_POS_W'(pstart_r);
          flush_tok.length = TOK_POS_W'(1);
        end
        M_ZERO, M_DEC, M_HEX: begin
          flush_v = 1'b1;
          flush_tok.kind = K_INT;
          flush_tok.value = acc_r;
          flush_tok.start = TOK_POS_W'(pstart_r);
          flush_tok.length = TOK_POS_W'(plen_r);
        end
        M_WORD: begin
          flush_v = 1'b1;
          flush_tok.kind = word_k;
          flush_tok.start = TOK_POS_W'(pstart_r);
          flush_tok.length = TOK_POS_W'(plen_r);
        end
        M_STRING: begin
          flush_v = 1'b1;
          flush_tok.kind = K_STR;
          flush_tok.start = TOK_POS_W'(pstart_r);
          flush_tok.length = TOK_POS_W'(plen_r);
          endpos = sat_inc(pos_r);
        end
        M_OP: begin
          flush_v = 1'b1;
          flush_tok.kind = op_one(pop_r);
          flush_tok.start = TOK_POS_W'(pstart_r);
          flush_tok.length = TOK_POS_W'(1);
        end
        default: ;
      endcase
      norm_v = 1'b1;
      norm_tok.kind = K_END;
      norm_tok.start = TOK_POS_W'(endpos);
      mode_nxt   = M_NORMAL;
      depth_nxt  = '0;
      pos_nxt    = '0;
      pstart_nxt = '0;
      plen_nxt   = '0;
      acc_nxt    = '0;
      pop_nxt    = '0;
    end else if (take) begin
      case (mode_r)
        M_SLASH: begin
          if (c == "/") mode_nxt = M_LINE;
          else if (c == "*") begin
            depth_nxt = DW'(1);
            mode_nxt = M_BLOCK;
          end else begin
            flush_v = 1'b1;
            flush_tok.kind = K_SLASH;
            flush_tok.start = TOK_POS_W'(pstart_r);
            flush_tok.length = TOK_POS_W'(1);
            do_norm = 1'b1;
          end
        end
        M_LINE: if (c == 8'd10) mode_nxt = M_NORMAL;
        M_BLOCK, M_BLOCK_SLASH, M_BLOCK_STAR: begin
          if (mode_r == M_BLOCK_SLASH && c == "*") begin
            if (depth_r < DW'(MAX_COMMENT_DEPTH)) depth_nxt = depth_r + 1'b1;
            mode_nxt = M_BLOCK;
          end else if (mode_r == M_BLOCK_STAR && c == "/") begin
            if (depth_r != '0) depth_nxt = depth_r - 1'b1;
            mode_nxt = (depth_nxt == '0) ? M_NORMAL : M_BLOCK;
          end else if (c == "/") mode_nxt = M_BLOCK_SLASH;
          else if (c == "*") mode_nxt = M_BLOCK_STAR;
          else mode_nxt = M_BLOCK;
        end
        M_ATTR: if (!word_char(c)) do_norm = 1'b1;
        M_ZERO, M_DEC: begin
          if (mode_r == M_ZERO && c == "x") begin
            mode_nxt = M_HEX;
            plen_nxt = sat_inc(plen_r);
          end else if (dec_char(c)) begin
            mode_nxt = M_DEC;
            acc_nxt = (acc_r << 3) + (acc_r << 1) + {28'd0, c[3:0]};
            plen_nxt = sat_inc(plen_r);
          end else begin
            flush_v = 1'b1;
            flush_tok.kind = K_INT;
            flush_tok.value = acc_r;
            flush_tok.start = TOK_POS_W'(pstart_r);
            flush_tok.length = TOK_POS_W'(plen_r);
            do_norm = 1'b1;
          end
        end
        M_HEX: begin
          if (hex_char(c)) begin
            acc_nxt = {acc_r[27:0], hex_val(c)};
            plen_nxt = sat_inc(plen_r);
          end else begin
            flush_v = 1'b1;
            flush_tok.kind = K_INT;
            flush_tok.value = acc_r;
            flush_tok.start = TOK_POS_W'(pstart_r);
            flush_tok.length = TOK_POS_W'(plen_r);
            do_norm = 1'b1;
          end
        end
        M_WORD: begin
          if (word_char(c)) begin
            pre_we = (plen_r < PW'(PREFIX_LEN));
            plen_nxt = sat_inc(plen_r);
          end else begin
            flush_v = 1'b1;
            flush_tok.kind = word_k;
            flush_tok.start = TOK_POS_W'(pstart_r);
            flush_tok.length = TOK_POS_W'(plen_r);
            do_norm = 1'b1;
          end
        end
        M_STRING: begin
          if (c == "\"") begin
            flush_v = 1'b1;
            flush_tok.kind = K_STR;
            flush_tok.start = TOK_POS_W'(pstart_r);
            flush_tok.length = TOK_POS_W'(plen_r);
            mode_nxt = M_NORMAL;
          end else plen_nxt = sat_inc(plen_r);
        end
        M_OP: begin
          flush_v = 1'b1;
          flush_tok.start = TOK_POS_W'(pstart_r);
          if (c == op_second(pop_r)) begin
            flush_tok.kind = op_two(pop_r);
            flush_tok.length = TOK_POS_W'(2);
            mode_nxt = M_NORMAL;
          end else begin
            flush_tok.kind = op_one(pop_r);
            flush_tok.length = TOK_POS_W'(1);
            do_norm = 1'b1;
          end
        end
        default: do_norm = 1'b1;
      endcase
      // The byte that ended a pending token starts over in normal mode.
      if (do_norm) begin
        mode_nxt = M_NORMAL;
        if (blank_char(c)) begin
        end else if (c == "/") begin
          mode_nxt = M_SLASH;
          pstart_nxt = pos_r;
        end else if (c == "@") begin
          mode_nxt = M_ATTR;
        end else if (dec_char(c)) begin
          mode_nxt = (c == "0") ? M_ZERO : M_DEC;
          pstart_nxt = pos_r;
          plen_nxt = PW'(1);
          acc_nxt = {28'd0, c[3:0]};
        end else if (word_lead(c)) begin
          mode_nxt = M_WORD;
          pstart_nxt = pos_r;
          plen_nxt = PW'(1);
          pre_we = 1'b1;
          pre_idx = 3'd0;
        end else if (c == "\"") begin
          mode_nxt = M_STRING;
          pstart_nxt = sat_inc(pos_r);
          plen_nxt = '0;
        end else if (op_second(c) != 8'd0) begin
          mode_nxt = M_OP;
          pop_nxt = c;
          pstart_nxt = pos_r;
        end else if (single_kind(c) != K_NONE) begin
          norm_v = 1'b1;
          norm_tok.kind = single_kind(c);
          norm_tok.start = TOK_POS_W'(pos_r);
          norm_tok.length = TOK_POS_W'(1);
        end
      end
      pos_nxt = sat_inc(pos_r);
    end
  end

  // Flushed token first, then the one the current byte makes.
  always_comb begin
    tok0 = flush_v ? flush_tok : norm_tok;
    tok1 = norm_tok;
    tok_n = {1'b0, flush_v} + {1'b0, norm_v};
    tok0.last = (tok_n == 2'd1);
    tok1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_NORMAL;
      depth_r  <= '0;
      pos_r    <= '0;
      pstart_r <= '0;
      plen_r   <= '0;
      acc_r    <= '0;
      pop_r    <= '0;
    end else begin
      mode_r   <= mode_nxt;
      depth_r  <= depth_nxt;
      pos_r    <= pos_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
      acc_r    <= acc_nxt;
      pop_r    <= pop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pre_we && pre_idx < 3'(PREFIX_LEN)) pre_r[pre_idx] <= c;
  end

endmodule

`default_nettype wire

>>> src/sbt_outq.sv
// ---------------------------------------------------------------------------
// sbt_outq: result token queue
// Four-entry queue that takes up to two tokens a cycle and gives one.
// ---------------------------------------------------------------------------
`default_nettype none

module sbt_outq import sbt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire token_t     tok0,
  input  wire token_t     tok1,
  input  wire logic [1:0] push_n,
  input  wire logic       pop,
  output token_t          head,
  output logic [2:0]      count
);

  token_t     mem [4];
  logic [1:0] wr_r, rd_r;
  logic [2:0] cnt_r;

  assign head  = mem[rd_r];
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_r] <= tok0;
    if (push_n == 2'd2) mem[wr_r + 2'd1] <= tok1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + push_n;
      rd_r  <= rd_r + {1'b0, pop};
      cnt_r <= cnt_r + {1'b0, push_n} - {2'b0, pop};
    end
  end

endmodule

`default_nettype wire

>>> src/source_byte_tokenizer_unit.sv
// ---------------------------------------------------------------------------
// source_byte_tokenizer_unit: streaming lexer top level
// A token is queued by the request that completes it and is output once the
// tokens before it are taken. Throughput: one byte request per cycle while
// the result queue has room for two tokens; the single output port gives one
// token a cycle unless stalled, and so paces bursts of two-token requests.
// Reset: synchronous active-low rst_n returns the scanner to normal mode at
// position zero and empties the result queue.
// ---------------------------------------------------------------------------
`default_nettype none

module source_byte_tokenizer_unit import sbt_pkg::*; #(
  parameter int unsigned POSITION_BITS     = POSITION_BITS_DEF,
  parameter int unsigned MAX_COMMENT_DEPTH = MAX_COMMENT_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_source_byte,
  input  wire logic                  in_end_of_source,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [5:0]                 out_token_kind,
  output logic signed [31:0]         out_token_value,
  output logic [TOK_POS_W-1:0]       out_token_start,
  output logic [TOK_POS_W-1:0]       out_token_length,
  output logic                       out_last_of_item
);

  token_t     tok0, tok1, head;
  logic [1:0] tok_n;
  logic [2:0] count;
  logic       take, pop;

  // A request is taken only when the queue can absorb the two tokens that
  // the worst-case byte produces, so no token is ever dropped.
  assign in_stall  = (count > 3'd2);
  assign take      = in_valid && !in_stall;
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;

  sbt_scan #(
    .POSITION_BITS     (POSITION_BITS),
    .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .c     (in_source_byte),
    .eos   (in_end_of_source),
    .tok0  (tok0),
    .tok1  (tok1),
    .tok_n (tok_n)
  );

  sbt_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .tok0   (tok0),
    .tok1   (tok1),
    .push_n (take ? tok_n : 2'd0),
    .pop    (pop),
    .head   (head),
    .count  (count)
  );

  assign out_token_kind   = head.kind;
  assign out_token_value  = head.value;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_last_of_item = head.last;

  // The queue never holds more than its four entries.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) count <= 3'd4)
    else $error("result queue overflow");

  // Closing the source always yields at least the end token.
  a_eos_tok: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_end_of_source) |-> (tok_n != 2'd0))
    else $error("close request produced no token");

  // Taking the last queued token with nothing pushed empties the output.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && count == 3'd1 && !(take && tok_n != 2'd0)) |=> !out_valid)
    else $error("output valid after draining last token");

endmodule

`default_nettype wire

>>> bench/source_byte_tokenizer_unit_test.sv
// ---------------------------------------------------------------------------
// source_byte_tokenizer_unit_test: self-checking bench of the tokenizer
// Source text is offered one byte request at a time. A lexer model inside
// the bench predicts the tokens, and every delivered token is compared
// field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module source_byte_tokenizer_unit_test import sbt_pkg::*;;

  // Punctuation kinds of the token tag.
  localparam logic [5:0] PUN_LPAREN = 6'd20, PUN_RPAREN = 6'd21, PUN_OPEN_BR = 6'd22;
  localparam logic [5:0] PUN_CLOSE_BR = 6'd23, PUN_SEP = 6'd24, PUN_SEMI = 6'd25;
  localparam logic [5:0] PUN_TYPE_SEP = 6'd26, PUN_RET_ARROW = 6'd27, PUN_ASSIGN = 6'd28;
  localparam logic [5:0] PUN_PLUS = 6'd29, PUN_MINUS = 6'd30, PUN_STAR = 6'd31;
  localparam logic [5:0] PUN_PERCENT = 6'd33, PUN_EQ = 6'd34, PUN_NE = 6'd35;
  localparam logic [5:0] PUN_LT = 6'd36, PUN_LE = 6'd37, PUN_GT = 6'd38, PUN_GE = 6'd39;
  localparam logic [5:0] PUN_AMP = 6'd40, PUN_PIPE = 6'd41, PUN_XOR = 6'd42;
  localparam logic [5:0] PUN_LOG_AND = 6'd43, PUN_OROR = 6'd44, PUN_BANG = 6'd45;

  localparam logic [19:0] POS_CAP   = 20'hFFFFF;
  localparam int          DEPTH_CAP = MAX_COMMENT_DEPTH_DEF;
  localparam int          STALL_LIMIT = 5000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          PHASE_ITEMS = 130;

  typedef struct packed {
    logic       close;
    logic [7:0] ch;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_source_byte = 8'd0;
  logic        in_end_of_source = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_token_kind;
  logic signed [31:0] out_token_value;
  logic [TOK_POS_W-1:0] out_token_start;
  logic [TOK_POS_W-1:0] out_token_length;
  logic        out_last_of_item;

  source_byte_tokenizer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_source_byte(in_source_byte), .in_end_of_source(in_end_of_source),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_kind(out_token_kind), .out_token_value(out_token_value),
    .out_token_start(out_token_start), .out_token_length(out_token_length),
    .out_last_of_item(out_last_of_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  request_t source_requests[$];   // requests waiting to be offered
  request_t offered;               // request currently on the input port
  token_t   expected_tokens[$];    // predicted tokens not yet delivered
  token_t   step_tokens[$];        // tokens caused by the request being predicted
  int       failures = 0;
  int       send_idle = 0;         // percent of cycles the sender idles
  int       recv_idle = 0;         // percent of cycles the receiver stalls
  int       hold_requests = 0;     // long receiver hold-offs asked for
  int       holds_started = 0;
  int       hold_left = 0;
  int       quiet_cycles = 0;

  // Lexer state mirrored by the bench.
  logic [19:0] lex_pos;
  mode_t       lex_mode;
  logic [7:0]  lex_depth;
  logic [19:0] lex_start;
  logic [19:0] lex_len;
  logic [31:0] lex_acc;
  logic [7:0]  lex_op;
  logic [7:0]  lex_prefix [0:5];

  string       kw_text [7] = '{"fn", "let", "mut", "if", "else", "while", "return"};
  logic [5:0]  kw_tag  [7] = '{K_FN, K_LET, K_MUT, K_IF, K_ELSE, K_WHILE, K_RET};

  function automatic logic [19:0] bump(input logic [19:0] v);
    return (v == POS_CAP) ? v : v + 20'd1;
  endfunction

  function automatic bit digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter_ch(input logic [7:0] c);
    return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit hex_ch(input logic [7:0] c);
    return digit_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [31:0] hex_weight(input logic [7:0] c);
    if (c <= "9") return 32'(c - "0");
    if (c <= "F") return 32'(c - "A") + 32'd10;
    return 32'(c - "a") + 32'd10;
  endfunction

  // Second byte that completes a two-byte operator, zero if none.
  function automatic logic [7:0] pair_byte(input logic [7:0] c);
    case (c)
      "=", "!", "<", ">": return "=";
      "-": return ">";
      "&": return "&";
      "|": return "|";
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [5:0] lone_op_kind(input logic [7:0] c);
    case (c)
      "=": return PUN_ASSIGN;
      "!": return PUN_BANG;
      "<": return PUN_LT;
      ">": return PUN_GT;
      "-": return PUN_MINUS;
      "&": return PUN_AMP;
      default: return PUN_PIPE;
    endcase
  endfunction

  function automatic logic [5:0] pair_op_kind(input logic [7:0] c);
    case (c)
      "=": return PUN_EQ;
      "!": return PUN_NE;
      "<": return PUN_LE;
      ">": return PUN_GE;
      "-": return PUN_RET_ARROW;
      "&": return PUN_LOG_AND;
      default: return PUN_OROR;
    endcase
  endfunction

  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    case (c)
      "(": return PUN_LPAREN;
      ")": return PUN_RPAREN;
      "{": return PUN_OPEN_BR;
      "}": return PUN_CLOSE_BR;
      ",": return PUN_SEP;
      ";": return PUN_SEMI;
      ":": return PUN_TYPE_SEP;
      "+": return PUN_PLUS;
      "*": return PUN_STAR;
      "%": return PUN_PERCENT;
      "^": return PUN_XOR;
      default: return K_END;
    endcase
  endfunction

  // A word is a keyword only when its length and every stored byte match.
  function automatic logic [5:0] word_tag();
    bit same;
    for (int k = 0; k < 7; k++) begin
      if (20'(kw_text[k].len()) == lex_len) begin
        same = 1;
        for (int i = 0; i < kw_text[k].len(); i++)
          if (lex_prefix[i] != kw_text[k][i]) same = 0;
        if (same) return kw_tag[k];
      end
    end
    return K_IDENT;
  endfunction

  task automatic put_token(input logic [5:0] k, input logic [31:0] v,
                           input logic [19:0] s, input logic [19:0] l);
    token_t t;
    if (step_tokens.size() < 2) begin
      t.kind = k;
      t.value = v;
      t.start = s;
      t.length = l;
      t.last = 1'b0;
      step_tokens.push_back(t);
    end
  endtask

  task automatic lex_clear();
    lex_pos = '0;
    lex_mode = M_NORMAL;
    lex_depth = '0;
    lex_start = '0;
    lex_len = '0;
    lex_acc = '0;
    lex_op = '0;
  endtask

  // Byte seen in normal mode, or the byte that ends a pending token.
  task automatic lex_fresh(input logic [7:0] c, input logic [19:0] p);
    lex_mode = M_NORMAL;
    if (c == " " || c == 8'd9 || c == 8'd10 || c == 8'd13) return;
    if (c == "/") begin
      lex_mode = M_SLASH;
      lex_start = p;
    end else if (c == "@") begin
      lex_mode = M_ATTR;
    end else if (digit_ch(c)) begin
      lex_mode = (c == "0") ? M_ZERO : M_DEC;
      lex_start = p;
      lex_len = 20'd1;
      lex_acc = 32'(c - "0");
    end else if (letter_ch(c)) begin
      lex_mode = M_WORD;
      lex_start = p;
      lex_len = 20'd1;
      lex_prefix[0] = c;
    end else if (c == "\"") begin
      lex_mode = M_STRING;
      lex_start = bump(p);
      lex_len = '0;
    end else if (pair_byte(c) != 8'd0) begin
      lex_mode = M_OP;
      lex_op = c;
      lex_start = p;
    end else if (punct_kind(c) != K_END) begin
      put_token(punct_kind(c), '0, p, 20'd1);
    end
  endtask

  task automatic lex_block(input logic [7:0] c);
    if (c == "/") lex_mode = M_BLOCK_SLASH;
    else if (c == "*") lex_mode = M_BLOCK_STAR;
    else lex_mode = M_BLOCK;
  endtask

  task automatic lex_byte(input logic [7:0] c);
    logic [19:0] p;
    p = lex_pos;
    case (lex_mode)
      M_SLASH: begin
        if (c == "/") lex_mode = M_LINE;
        else if (c == "*") begin
          lex_depth = 8'd1;
          lex_mode = M_BLOCK;
        end else begin
          put_token(K_SLASH, '0, lex_start, 20'd1);
          lex_fresh(c, p);
        end
      end
      M_LINE: if (c == 8'd10) lex_mode = M_NORMAL;
      M_BLOCK: lex_block(c);
      M_BLOCK_SLASH: begin
        if (c == "*") begin
          if (lex_depth < 8'(DEPTH_CAP)) lex_depth++;
          lex_mode = M_BLOCK;
        end else lex_block(c);
      end
      M_BLOCK_STAR: begin
        if (c == "/") begin
          if (lex_depth > 8'd0) lex_depth--;
          lex_mode = (lex_depth == 8'd0) ? M_NORMAL : M_BLOCK;
        end else lex_block(c);
      end
      M_ATTR: if (!(letter_ch(c) || digit_ch(c))) lex_fresh(c, p);
      M_ZERO, M_DEC: begin
        if (lex_mode == M_ZERO && c == "x") begin
          lex_mode = M_HEX;
          lex_len = bump(lex_len);
        end else if (digit_ch(c)) begin
          lex_mode = M_DEC;
          lex_acc = lex_acc * 32'd10 + 32'(c - "0");
          lex_len = bump(lex_len);
        end else begin
          put_token(K_INT, lex_acc, lex_start, lex_len);
          lex_fresh(c, p);
        end
      end
      M_HEX: begin
        if (hex_ch(c)) begin
          lex_acc = lex_acc * 32'd16 + hex_weight(c);
          lex_len = bump(lex_len);
        end else begin
          put_token(K_INT, lex_acc, lex_start, lex_len);
          lex_fresh(c, p);
        end
      end
      M_WORD: begin
        if (letter_ch(c) || digit_ch(c)) begin
          if (lex_len < 20'd6) lex_prefix[lex_len[2:0]] = c;
          lex_len = bump(lex_len);
        end else begin
          put_token(word_tag(), '0, lex_start, lex_len);
          lex_fresh(c, p);
        end
      end
      M_STRING: begin
        if (c == "\"") begin
          put_token(K_STR, '0, lex_start, lex_len);
          lex_mode = M_NORMAL;
        end else lex_len = bump(lex_len);
      end
      M_OP: begin
        if (c == pair_byte(lex_op)) begin
          put_token(pair_op_kind(lex_op), '0, lex_start, 20'd2);
          lex_mode = M_NORMAL;
        end else begin
          put_token(lone_op_kind(lex_op), '0, lex_start, 20'd1);
          lex_fresh(c, p);
        end
      end
      default: lex_fresh(c, p);
    endcase
    lex_pos = bump(p);
  endtask

  // Closing request: flush what is pending, then the end token.
  task automatic lex_close();
    logic [19:0] end_pos;
    end_pos = lex_pos;
    case (lex_mode)
      M_SLASH: put_token(K_SLASH, '0, lex_start, 20'd1);
      M_ZERO, M_DEC, M_HEX: put_token(K_INT, lex_acc, lex_start, lex_len);
      M_WORD: put_token(word_tag(), '0, lex_start, lex_len);
      M_STRING: begin
        put_token(K_STR, '0, lex_start, lex_len);
        end_pos = bump(end_pos);
      end
      M_OP: put_token(lone_op_kind(lex_op), '0, lex_start, 20'd1);
      default: ;
    endcase
    put_token(K_END, '0, end_pos, '0);
    lex_clear();
  endtask

  task automatic predict_tokens(input request_t r);
    step_tokens.delete();
    if (r.close) lex_close();
    else lex_byte(r.ch);
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endtask

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    failures++;
  endtask

  // Driver: a new request may be placed whenever the port is free or the
  // current one has just been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_tokens(offered);
      if (!in_valid || !in_stall) begin
        if (source_requests.size() > 0 && $urandom_range(99) >= send_idle) begin
          offered = source_requests.pop_front();
          in_valid <= 1'b1;
          in_source_byte <= offered.ch;
          in_end_of_source <= offered.close;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks delivered tokens and drives the receiver stall. A long
  // hold-off, once asked for, is counted down here.
  always @(posedge clk) begin
    token_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("kind of a token with no prediction", -1, out_token_kind);
        end else begin
          want = expected_tokens.pop_front();
          if (out_token_kind !== want.kind)
            report_mismatch("kind", want.kind, out_token_kind);
          if (out_token_value !== want.value)
            report_mismatch("value", want.value, out_token_value);
          if (out_token_start !== want.start)
            report_mismatch("start", want.start, out_token_start);
          if (out_token_length !== want.length)
            report_mismatch("length", want.length, out_token_length);
          if (out_last_of_item !== want.last)
            report_mismatch("last_of_item", want.last, out_last_of_item);
        end
      end
      if (holds_started != hold_requests) begin
        holds_started <= hold_requests;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // Watchdog: too long without any request or token moving ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic add_byte(input logic [7:0] c);
    request_t r;
    r.close = 1'b0;
    r.ch = c;
    source_requests.push_back(r);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // The byte of a closing request is ignored, so it carries random bits.
  task automatic add_close();
    request_t r;
    r.close = 1'b1;
    r.ch = 8'($urandom_range(255));
    source_requests.push_back(r);
  endtask

  function automatic logic [7:0] any_letter();
    case ($urandom_range(3))
      0: return 8'("a" + $urandom_range(25));
      1: return 8'("A" + $urandom_range(25));
      2: return 8'("0" + $urandom_range(9));
      default: return "_";
    endcase
  endfunction

  function automatic logic [7:0] any_hex();
    string h = "0123456789abcdefABCDEF";
    return h[$urandom_range(21)];
  endfunction

  // One random fragment of source text; most are well formed tokens.
  task automatic add_fragment();
    string keys = "=!<>-&|";
    string puncts = "(){},;:+*%^";
    logic [7:0] c;
    case ($urandom_range(16))
      0: begin
        add_text(kw_text[$urandom_range(6)]);
        if ($urandom_range(2) == 0) add_byte(any_letter());
      end
      1: begin
        add_byte(8'("a" + $urandom_range(25)));
        repeat ($urandom_range(8)) add_byte(any_letter());
      end
      2: begin
        add_byte(8'("1" + $urandom_range(8)));
        repeat ($urandom_range(13)) add_byte(8'("0" + $urandom_range(9)));
      end
      3: begin
        add_text("0x");
        repeat ($urandom_range(10)) add_byte(any_hex());
      end
      4: begin
        add_byte("0");
        if ($urandom_range(1) == 0) add_byte(8'("0" + $urandom_range(9)));
      end
      5: begin
        add_byte("\"");
        repeat ($urandom_range(7)) begin
          c = 8'(32 + $urandom_range(94));
          add_byte(c == "\"" ? "q" : c);
        end
        if ($urandom_range(3) == 0) add_close();
        else add_byte("\"");
      end
      6, 7: begin
        c = keys[$urandom_range(6)];
        add_byte(c);
        if ($urandom_range(1) == 0) add_byte(pair_byte(c));
      end
      8: add_byte(puncts[$urandom_range(10)]);
      9: begin
        add_text("//");
        repeat ($urandom_range(5)) add_byte(any_letter());
        add_byte(8'd10);
      end
      10: add_text($urandom_range(1) ? "/* a /* * / */ b */" : "/*/**/*/");
      11: begin
        add_byte("@");
        repeat ($urandom_range(4)) add_byte(any_letter());
      end
      12: add_byte($urandom_range(1) ? " " : 8'(9 + 4 * $urandom_range(1)));
      13: add_byte("/");
      14: add_byte(8'($urandom_range(255)));
      15: add_close();
      default: add_byte(8'd13);
    endcase
    if ($urandom_range(2) == 0) add_byte(" ");
  endtask

  task automatic wait_drained();
    while (source_requests.size() > 0 || in_valid || expected_tokens.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    lex_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: keyword against operator lookahead, hex of both
    // cases, a line comment, an attribute, unknown bytes, and a string that
    // the closing request cuts off.
    add_text("if x1>=0xAf//c\n@t");
    add_byte(8'd0);
    add_byte(8'hFF);
    add_text("\"ab");
    add_close();
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 30 : (phase == 1) ? 69 : 0;
      recv_idle = (phase == 0) ? 69 : (phase == 1) ? 30 : 0;
      while (source_requests.size() < PHASE_ITEMS) add_fragment();
      if (phase == 2) begin
        // Start a fresh source so no pending comment or string hides the
        // nesting. Nest deeper than the depth counter holds, then close as
        // many as it can count, so the comment ends and a word follows.
        add_close();
        repeat (DEPTH_CAP + 5) add_text("/*");
        repeat (DEPTH_CAP) add_text("*/");
        add_text(" fn ");
        add_close();
      end
      add_close();
      if (phase == 0) hold_requests = 1;
      // The sender waits here until every predicted token has arrived.
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (failures == 0 && expected_tokens.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
src/sbt_pkg.sv
src/sbt_scan.sv
src/sbt_outq.sv
src/source_byte_tokenizer_unit.sv
bench/source_byte_tokenizer_unit_test.sv
